// ----- rtl/core/midpoint_circle_point_generator_assert.svh -----
// assertion macros shared by the circle point generator files
`ifndef MIDPOINT_CIRCLE_POINT_GENERATOR_ASSERT_SVH
`define MIDPOINT_CIRCLE_POINT_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define MCPG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define MCPG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define MCPG_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCPG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/core/mcpg_pkg.sv -----
`timescale 1ns / 1ps

package mcpg_pkg;

    // field widths
    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 11;
    localparam int OUT_BITS    = COORD_BITS + 2;
    // signed walk offsets, wide enough for r-1 and a final step below zero
    localparam int X_BITS      = RADIUS_BITS + 1;
    // signed decision error, step sizes and doubled radius
    localparam int ERR_BITS    = RADIUS_BITS + 4;

    // points per step and index width
    localparam int POINTS_PER_STEP = 8;
    localparam int IDX_BITS        = $clog2(POINTS_PER_STEP);

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // command codes
    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd;

    // one step job handed from front to back
    typedef struct packed {
        logic [COORD_BITS-1:0]    cx;
        logic [COORD_BITS-1:0]    cy;
        logic signed [X_BITS-1:0] x;
        logic signed [X_BITS-1:0] y;
        logic                     done;
        logic                     empty;
    } t_job;

endpackage

// ----- rtl/core/mcpg_if.sv -----
`timescale 1ns / 1ps

// request channel: start or step commands
interface mcpg_cmd_if;
    import mcpg_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [COORD_BITS-1:0]  centre_x;
    logic [COORD_BITS-1:0]  centre_y;
    logic [RADIUS_BITS-1:0] radius_in;

    modport source (output valid, command, centre_x, centre_y, radius_in, input ready);
    modport sink   (input valid, command, centre_x, centre_y, radius_in, output ready);
endinterface

// result channel: eight points per step request, or one empty result
interface mcpg_pt_if;
    import mcpg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] point_x;
    logic signed [OUT_BITS-1:0] point_y;
    logic                       last_of_step;
    logic                       circle_done;
    logic                       no_point;

    modport source (output valid, point_x, point_y, last_of_step, circle_done, no_point,
                    input ready);
    modport sink   (input valid, point_x, point_y, last_of_step, circle_done, no_point,
                    output ready);
endinterface

// ----- rtl/core/mcpg_front.sv -----
`timescale 1ns / 1ps

module mcpg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mcpg_cmd_if.sink          i_cmd,
    input  logic              i_full,
    output logic              o_push,
    output mcpg_pkg::t_job    o_job
);
    import mcpg_pkg::*;

    // walk state
    logic [COORD_BITS-1:0]    r_cx;
    logic [COORD_BITS-1:0]    r_cy;
    logic signed [X_BITS-1:0] r_x;
    logic signed [X_BITS-1:0] r_y;
    logic signed [ERR_BITS-1:0] r_tx;
    logic signed [ERR_BITS-1:0] r_ty;
    logic signed [ERR_BITS-1:0] r_err;
    logic signed [ERR_BITS-1:0] r_two_r;
    logic                     r_active;

    logic                     w_accept;
    logic                     w_is_start;
    logic                     w_err_le0;
    logic                     w_e1_gt0;
    logic signed [ERR_BITS-1:0] w_e1;
    logic signed [X_BITS-1:0] w_y1;
    logic signed [ERR_BITS-1:0] w_ty1;
    logic signed [X_BITS-1:0] n_x;
    logic signed [X_BITS-1:0] n_y;
    logic signed [ERR_BITS-1:0] n_tx;
    logic signed [ERR_BITS-1:0] n_ty;
    logic signed [ERR_BITS-1:0] n_err;
    logic                     n_active;
    logic signed [ERR_BITS-1:0] w_rad_ext;
    logic signed [ERR_BITS-1:0] w_two_r_in;

    assign i_cmd.ready = !i_full;
    assign w_accept    = i_cmd.valid && !i_full;
    assign w_is_start  = (i_cmd.command == CMD_START);

    // start values from the request
    assign w_rad_ext  = {{(ERR_BITS-RADIUS_BITS){1'b0}}, i_cmd.radius_in};
    assign w_two_r_in = w_rad_ext <<< 1;

    // one midpoint update: minor axis first, then major axis
    always_comb begin
        w_err_le0 = r_err[ERR_BITS-1] || (r_err == '0);
        w_e1  = r_err;
        w_y1  = r_y;
        w_ty1 = r_ty;
        if (w_err_le0) begin
            w_e1  = r_err + r_ty;
            w_y1  = r_y + X_BITS'(1);
            w_ty1 = r_ty + ERR_BITS'(2);
        end
        w_e1_gt0 = !w_e1[ERR_BITS-1] && (w_e1 != '0);
        n_x   = r_x;
        n_tx  = r_tx;
        n_err = w_e1;
        if (w_e1_gt0) begin
            n_x   = r_x - X_BITS'(1);
            n_tx  = r_tx + ERR_BITS'(2);
            n_err = w_e1 + r_tx + ERR_BITS'(2) - r_two_r;
        end
        n_y      = w_y1;
        n_ty     = w_ty1;
        n_active = (n_x >= n_y);
    end

    // state update on accepted requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_tx     <= ERR_BITS'(1);
            r_ty     <= ERR_BITS'(1);
            r_err    <= '0;
            r_two_r  <= '0;
            r_active <= 1'b0;
        end else if (w_accept) begin
            if (w_is_start) begin
                r_cx     <= i_cmd.centre_x;
                r_cy     <= i_cmd.centre_y;
                r_x      <= {1'b0, i_cmd.radius_in} - X_BITS'(1);
                r_y      <= '0;
                r_tx     <= ERR_BITS'(1);
                r_ty     <= ERR_BITS'(1);
                r_err    <= ERR_BITS'(1) - w_two_r_in;
                r_two_r  <= w_two_r_in;
                r_active <= (i_cmd.radius_in != '0);
            end else if (r_active) begin
                r_x      <= n_x;
                r_y      <= n_y;
                r_tx     <= n_tx;
                r_ty     <= n_ty;
                r_err    <= n_err;
                r_active <= n_active;
            end
        end
    end

    // job for the back end, taken from the state before the update
    assign o_push      = w_accept && !w_is_start;
    assign o_job.cx    = r_cx;
    assign o_job.cy    = r_cy;
    assign o_job.x     = r_x;
    assign o_job.y     = r_y;
    assign o_job.done  = r_active && !n_active;
    assign o_job.empty = !r_active;

endmodule

// ----- rtl/core/mcpg_queue.sv -----
`timescale 1ns / 1ps

`include "midpoint_circle_point_generator_assert.svh"

module mcpg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mcpg_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output mcpg_pkg::t_job o_head
);
    import mcpg_pkg::*;

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_full    = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_head    = r_mem[r_rd_ptr];

    // pointer wrap
    function automatic logic [QPTR_BITS-1:0] f_next(input logic [QPTR_BITS-1:0] p);
        f_next = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
    endfunction

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (w_do_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + QCNT_BITS'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - QCNT_BITS'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `MCPG_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > QCNT_BITS'(QUEUE_DEPTH), "queue count above depth")
    `MCPG_ASSERT(a_push_grows, i_clk, i_rst_n, w_do_push && !w_do_pop |=> r_count == $past(r_count) + QCNT_BITS'(1), "push did not grow queue")
    `MCPG_ASSERT(a_pop_shrinks, i_clk, i_rst_n, w_do_pop && !w_do_push |=> r_count == $past(r_count) - QCNT_BITS'(1), "pop did not shrink queue")

endmodule

// ----- rtl/core/mcpg_back.sv -----
`timescale 1ns / 1ps

`include "midpoint_circle_point_generator_assert.svh"

module mcpg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  mcpg_pkg::t_job i_head,
    output logic           o_pop,
    mcpg_pt_if.source      o_pt
);
    import mcpg_pkg::*;

    logic [IDX_BITS-1:0]  r_idx;
    logic                 r_valid;
    logic [OUT_BITS-1:0]  r_px;
    logic [OUT_BITS-1:0]  r_py;
    logic                 r_last;
    logic                 r_done;
    logic                 r_no_point;

    logic                 w_load;
    logic                 w_last_sel;
    logic signed [X_BITS-1:0] w_a;
    logic signed [X_BITS-1:0] w_b;
    logic [OUT_BITS-1:0]  w_a_ext;
    logic [OUT_BITS-1:0]  w_b_ext;
    logic [OUT_BITS-1:0]  w_cx_ext;
    logic [OUT_BITS-1:0]  w_cy_ext;
    logic [OUT_BITS-1:0]  n_px;
    logic [OUT_BITS-1:0]  n_py;

    // output register may take a new point
    assign w_load     = !r_valid || o_pt.ready;
    assign w_last_sel = i_head.empty || (r_idx == IDX_BITS'(POINTS_PER_STEP - 1));
    assign o_pop      = w_load && !i_empty && w_last_sel;

    // octant mirror: bit 2 swaps axes, bit 1 negates column offset, bit 0 picks row sign
    always_comb begin
        w_a      = r_idx[2] ? i_head.y : i_head.x;
        w_b      = r_idx[2] ? i_head.x : i_head.y;
        w_a_ext  = {{(OUT_BITS-X_BITS){w_a[X_BITS-1]}}, w_a};
        w_b_ext  = {{(OUT_BITS-X_BITS){w_b[X_BITS-1]}}, w_b};
        w_cx_ext = {{(OUT_BITS-COORD_BITS){1'b0}}, i_head.cx};
        w_cy_ext = {{(OUT_BITS-COORD_BITS){1'b0}}, i_head.cy};
        n_px     = r_idx[1] ? (w_cx_ext - w_a_ext) : (w_cx_ext + w_a_ext);
        n_py     = r_idx[0] ? (w_cy_ext + w_b_ext) : (w_cy_ext - w_b_ext);
        if (i_head.empty) begin
            n_px = '0;
            n_py = '0;
        end
    end

    // control: valid flag and point index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_idx <= w_last_sel ? '0 : r_idx + IDX_BITS'(1);
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load && !i_empty) begin
            r_px       <= n_px;
            r_py       <= n_py;
            r_last     <= w_last_sel;
            r_done     <= i_head.done && !i_head.empty;
            r_no_point <= i_head.empty;
        end
    end

    assign o_pt.valid        = r_valid;
    assign o_pt.point_x      = r_px;
    assign o_pt.point_y      = r_py;
    assign o_pt.last_of_step = r_last;
    assign o_pt.circle_done  = r_done;
    assign o_pt.no_point     = r_no_point;

    `MCPG_ASSERT(a_mid_step_head, i_clk, i_rst_n, r_idx != '0 |-> !i_empty && !i_head.empty, "head lost during a step")
    `MCPG_ASSERT(a_pop_restarts, i_clk, i_rst_n, o_pop |=> r_idx == '0, "index not cleared after pop")
    `MCPG_ASSERT(a_empty_is_last, i_clk, i_rst_n, r_valid && r_no_point |-> r_last && !r_done, "empty result not single")

endmodule

// ----- rtl/core/midpoint_circle_point_generator.sv -----
`timescale 1ns / 1ps

// Midpoint circle point generator.
// i_cmd carries requests: command 0 (start) loads centre_x, centre_y and
// radius_in and yields nothing; command 1 (step) yields eight mirrored
// points of the current circle on o_pt, the eighth with last_of_step, or
// one result with no_point and last_of_step when no circle is active.
// circle_done marks all points of the step that ends the circle.
// A step request is classified and the walk state advanced in the cycle it
// is accepted; its job enters a two-entry queue and the point stage emits
// one point per cycle from its output register while o_pt.ready is high.
// The job passes through the queue and the output register before its
// first point appears on o_pt. A step yields eight points (one when empty)
// through the single point stage; starts produce nothing.
// When the receiver holds o_pt.ready low the point stage holds, the queue
// fills and i_cmd.ready drops once both queue entries are taken.
// Synchronous reset clears the walk (no circle active) and empties the queue.
module midpoint_circle_point_generator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mcpg_cmd_if.sink  i_cmd,
    mcpg_pt_if.source o_pt
);
    import mcpg_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_job w_job;
    t_job w_head;

    // request classification and walk update
    mcpg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job)
    );

    // job queue
    mcpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // point emission
    mcpg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_pt    (o_pt)
    );

endmodule

// ----- dv/mcpg_point_checker.sv -----
`timescale 1ns / 1ps

// watches both channels, predicts the points of every request and compares
module mcpg_point_checker
    import mcpg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mcpg_cmd_if  i_cmd,
    mcpg_pt_if   i_pt,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_points_seen
);

    // one point as it appears on the result channel
    typedef struct packed {
        logic signed [OUT_BITS-1:0] px;
        logic signed [OUT_BITS-1:0] py;
        logic                       last;
        logic                       done;
        logic                       empty;
    } t_circle_point;

    // walk state of the circle being traced
    logic [COORD_BITS-1:0]      centre_col;
    logic [COORD_BITS-1:0]      centre_row;
    logic signed [ERR_BITS-1:0] twice_radius;
    logic signed [ERR_BITS-1:0] step_major;
    logic signed [ERR_BITS-1:0] step_minor;
    logic signed [ERR_BITS-1:0] decision_error;
    logic signed [X_BITS-1:0]   offset_major;
    logic signed [X_BITS-1:0]   offset_minor;
    bit                         circle_active;

    t_circle_point expected_points[$];
    int            fail_count  = 0;
    int            points_seen = 0;

    // count a mismatch, print only the first few
    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= 40) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // start request: load centre and radius, prime the walk
    task automatic load_circle(input logic [COORD_BITS-1:0] col,
                               input logic [COORD_BITS-1:0] row,
                               input logic [RADIUS_BITS-1:0] radius);
        int rad;
        rad            = int'(radius);
        centre_col     = col;
        centre_row     = row;
        twice_radius   = ERR_BITS'(2 * rad);
        offset_major   = X_BITS'(rad - 1);
        offset_minor   = '0;
        step_major     = ERR_BITS'(1);
        step_minor     = ERR_BITS'(1);
        decision_error = ERR_BITS'(1 - 2 * rad);
        // zero radius leaves no circle to walk
        circle_active  = (offset_major >= offset_minor);
    endtask

    function automatic void queue_point(input int col, input int row, input bit last,
                                        input bit done);
        expected_points.push_back('{px: OUT_BITS'(col), py: OUT_BITS'(row),
                                    last: last, done: done, empty: 1'b0});
    endfunction

    // step request: eight mirrored points, then advance the walk
    task automatic plot_step();
        int x, y, cx, cy;
        bit done;
        if (!circle_active) begin
            // step without circle gives a single empty point
            expected_points.push_back('{px: '0, py: '0, last: 1'b1, done: 1'b0,
                                        empty: 1'b1});
            return;
        end
        x  = int'(offset_major);
        y  = int'(offset_minor);
        cx = int'(centre_col);
        cy = int'(centre_row);
        if (decision_error <= 0) begin
            offset_minor   = offset_minor + X_BITS'(1);
            decision_error = decision_error + step_minor;
            step_minor     = step_minor + ERR_BITS'(2);
        end
        if (decision_error > 0) begin
            offset_major   = offset_major - X_BITS'(1);
            step_major     = step_major + ERR_BITS'(2);
            decision_error = decision_error + step_major - twice_radius;
        end
        // circle ends once the major offset drops below the minor one
        circle_active = (offset_major >= offset_minor);
        done          = !circle_active;
        queue_point(cx + x, cy - y, 1'b0, done);
        queue_point(cx + x, cy + y, 1'b0, done);
        queue_point(cx - x, cy - y, 1'b0, done);
        queue_point(cx - x, cy + y, 1'b0, done);
        queue_point(cx + y, cy - x, 1'b0, done);
        queue_point(cx + y, cy + x, 1'b0, done);
        queue_point(cx - y, cy - x, 1'b0, done);
        queue_point(cx - y, cy + x, 1'b1, done);
    endtask

    // compare one accepted point with the oldest prediction
    task automatic check_point(input t_circle_point got);
        t_circle_point want;
        points_seen++;
        if (expected_points.size() == 0) begin
            report_mismatch("unexpected point, point_x", int'(got.px), 0);
            return;
        end
        want = expected_points.pop_front();
        if (got.px !== want.px)       report_mismatch("point_x", int'(got.px), int'(want.px));
        if (got.py !== want.py)       report_mismatch("point_y", int'(got.py), int'(want.py));
        if (got.last !== want.last)   report_mismatch("last_of_step", got.last, want.last);
        if (got.done !== want.done)   report_mismatch("circle_done", got.done, want.done);
        if (got.empty !== want.empty) report_mismatch("no_point", got.empty, want.empty);
    endtask

    // sample both channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            centre_col     = '0;
            centre_row     = '0;
            twice_radius   = '0;
            offset_major   = '0;
            offset_minor   = '0;
            step_major     = ERR_BITS'(1);
            step_minor     = ERR_BITS'(1);
            decision_error = '0;
            circle_active  = 1'b0;
            expected_points.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                if (i_cmd.command == CMD_START) begin
                    load_circle(i_cmd.centre_x, i_cmd.centre_y, i_cmd.radius_in);
                end else begin
                    plot_step();
                end
            end
            if (i_pt.valid && i_pt.ready) begin
                check_point('{px: i_pt.point_x, py: i_pt.point_y, last: i_pt.last_of_step,
                              done: i_pt.circle_done, empty: i_pt.no_point});
            end
        end
        o_pending     <= expected_points.size();
        o_fail_count  <= fail_count;
        o_points_seen <= points_seen;
    end

endmodule

// ----- dv/tb_midpoint_circle_point_generator.sv -----
`timescale 1ns / 1ps

module tb_midpoint_circle_point_generator;
    import mcpg_pkg::*;

    localparam int TOTAL_REQUESTS = 355;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int fail_count;
    int points_pending;
    int points_seen;

    int  requests_sent = 0;
    int  starts_sent   = 0;
    int  steps_sent    = 0;
    int  idle_cycles   = 0;
    bit  steady_flow   = 1'b0;
    bit  long_hold_req = 1'b0;
    bit  hold_active   = 1'b0;

    mcpg_cmd_if cmd_chan ();
    mcpg_pt_if  pt_chan ();

    midpoint_circle_point_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_chan),
        .o_pt    (pt_chan)
    );

    mcpg_point_checker point_scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_chan),
        .i_pt          (pt_chan),
        .o_fail_count  (fail_count),
        .o_pending     (points_pending),
        .o_points_seen (points_seen)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // gap length: mostly short, a few long, none in steady phases
    function automatic int pick_gap();
        int roll;
        if (steady_flow) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // radius: mostly small circles, a few up to the largest
    function automatic logic [RADIUS_BITS-1:0] pick_radius();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return '0;
        if (roll < 80) return RADIUS_BITS'($urandom_range(1, 24));
        if (roll < 95) return RADIUS_BITS'($urandom_range(25, 200));
        return RADIUS_BITS'($urandom_range(201, 2047));
    endfunction

    // offer one request until accepted, then maybe idle
    task automatic send_request(input t_cmd cmd, input logic [COORD_BITS-1:0] cx,
                                input logic [COORD_BITS-1:0] cy,
                                input logic [RADIUS_BITS-1:0] radius);
        int gap;
        cmd_chan.valid     <= 1'b1;
        cmd_chan.command   <= cmd;
        cmd_chan.centre_x  <= cx;
        cmd_chan.centre_y  <= cy;
        cmd_chan.radius_in <= radius;
        @(posedge i_clk);
        while (!cmd_chan.ready) @(posedge i_clk);
        requests_sent++;
        if (cmd == CMD_START) starts_sent++;
        else steps_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_chan.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // step request, the unused fields carry noise
    task automatic send_step();
        send_request(CMD_STEP, COORD_BITS'($urandom_range(0, 4095)),
                     COORD_BITS'($urandom_range(0, 4095)),
                     RADIUS_BITS'($urandom_range(0, 2047)));
    endtask

    task automatic send_random_start(input logic [RADIUS_BITS-1:0] radius);
        send_request(CMD_START, COORD_BITS'($urandom_range(0, 4095)),
                     COORD_BITS'($urandom_range(0, 4095)), radius);
    endtask

    // stop offering and wait for every predicted point
    task automatic hold_sender_until_drained();
        cmd_chan.valid <= 1'b0;
        @(posedge i_clk);
        while (points_pending != 0) @(posedge i_clk);
    endtask

    // result side: random ready with gaps, one long hold on demand
    initial begin : result_sink
        int run;
        int gap;
        pt_chan.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_active   = 1'b1;
                pt_chan.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_active   = 1'b0;
            end else begin
                run = steady_flow ? 16 : $urandom_range(1, 12);
                pt_chan.ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    pt_chan.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // watchdog on cycles without any accepted request or point
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_chan.valid && cmd_chan.ready) || (pt_chan.valid && pt_chan.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [RADIUS_BITS-1:0] radius;
        int                     steps;
        int                     step_cap;
        bit                     hold_done;
        bit                     drain_done;
        hold_done          = 1'b0;
        drain_done         = 1'b0;
        cmd_chan.valid     = 1'b0;
        cmd_chan.command   = CMD_STEP;
        cmd_chan.centre_x  = '0;
        cmd_chan.centre_y  = '0;
        cmd_chan.radius_in = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // step with no circle loaded
        send_step();
        // zero radius at the far corner
        send_request(CMD_START, 12'hFFF, 12'hFFF, '0);
        send_step();
        // unit radius at the origin, ends after one step
        send_request(CMD_START, '0, '0, 11'd1);
        send_step();
        send_step();
        // largest radius, points far past both edges
        send_request(CMD_START, 12'hFFF, '0, 11'h7FF);
        repeat (3) send_step();
        send_request(CMD_START, '0, 12'hFFF, 11'h7FF);
        repeat (2) send_step();
        // new start drops the running circle, walk to its end and beyond
        send_request(CMD_START, 12'd2048, 12'd2048, 11'd5);
        repeat (6) send_step();
        send_request(CMD_START, 12'hFFF, 12'hFFF, 11'd3);
        repeat (3) send_step();

        // random circles with occasional stray requests
        while (requests_sent < TOTAL_REQUESTS) begin
            if (!hold_done && requests_sent >= 140) begin
                // long result hold while steps keep coming
                send_random_start(11'd40);
                cmd_chan.valid <= 1'b0;
                long_hold_req = 1'b1;
                do @(posedge i_clk); while (!hold_active);
                steady_flow = 1'b1;
                repeat (8) send_step();
                steady_flow = 1'b0;
                hold_done   = 1'b1;
            end
            if (!drain_done && requests_sent >= 240) begin
                hold_sender_until_drained();
                drain_done = 1'b1;
            end
            steady_flow = (requests_sent >= 280 && requests_sent < 330);
            if ($urandom_range(0, 19) == 0) begin
                send_step();
            end else begin
                radius = pick_radius();
                send_random_start(radius);
                step_cap = int'(radius) * 3 / 4 + 3;
                if (step_cap > 40) step_cap = 40;
                steps = $urandom_range(1, step_cap);
                repeat (steps) begin
                    if ($urandom_range(0, 11) == 0) send_random_start(pick_radius());
                    send_step();
                end
            end
        end
        steady_flow = 1'b0;

        // drain and let any stray point show up
        hold_sender_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d start and %0d step requests, %0d points checked",
                 starts_sent, steps_sent, points_seen);
        $display("included a %0d-cycle result hold, a full drain and gap-free phases",
                 LONG_HOLD);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
